// ===== rtl/bole_pkg.sv =====
package bole_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_PUSH_FRONT = 4'd0;
    localparam t_mode MODE_PUSH_BACK  = 4'd1;
    localparam t_mode MODE_POP_FRONT  = 4'd2;
    localparam t_mode MODE_INSERT_NEW = 4'd3;
    localparam t_mode MODE_REMOVE     = 4'd4;
    localparam t_mode MODE_READ_INDEX = 4'd5;
    localparam t_mode MODE_FRONT      = 4'd6;
    localparam t_mode MODE_BACK       = 4'd7;
    localparam t_mode MODE_CLEAR      = 4'd8;
    localparam t_mode MODE_DUMP_FWD   = 4'd9;
    localparam t_mode MODE_DUMP_REV   = 4'd10;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_EMPTY     = 3'd1;
    localparam t_status ST_RANGE     = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_PRESENT   = 3'd4;
    localparam t_status ST_NOT_FOUND = 3'd5;

endpackage

// ===== rtl/bole_ram.sv =====
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             i_mode, i_value, i_position
// result    out        o_valid (once per result) o_data, o_status, o_count, o_last
//
// Each command passes through the decode state S_EXEC, then its walk over the list held
// in a single one-read, one-write RAM. Push, clear and errors found at decode end there;
// reads and pop go to S_READ; insert-if-absent scans a non-empty list in S_SCAN; remove
// closes any gap in S_SHIFT after S_SCAN, since the gap-closing copy carries on from the
// match without a second pass; a dump gives one result per cycle. The list is a circular
// buffer, so a push or pop at the front moves no data. Reset empties the list at once; the
// RAM contents are never cleared. The receiver cannot stall, so results are never held.
module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_data,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DUMP  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_held, n_held;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_idx, n_idx;
    t_mode                 r_mode;
    logic [DATA_WIDTH-1:0] r_value;
    logic [POS_W-1:0]      r_pos;

    logic                  n_emit;
    logic [DATA_WIDTH-1:0] n_data;
    t_status               n_status;
    logic                  n_last;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    logic [63:0]           w_in64;
    logic [63:0]           w_out64;
    logic [15:0]           w_held16;
    logic                  w_full;
    logic                  w_at_end;
    logic [AW-1:0]         w_idx_inc;
    logic [AW-1:0]         w_head_dec;
    logic [AW-1:0]         w_tail;

    // Maps a position in the list to its RAM slot behind the head pointer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign w_in64     = 64'(i_value);
    assign w_full     = (r_held == CW'(DEPTH));
    assign w_at_end   = ((CW'(r_idx) + CW'(1)) == r_held);
    assign w_idx_inc  = r_idx + AW'(1);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : (r_head - AW'(1));
    assign w_tail     = AW'(r_held - CW'(1));

    bole_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_state == S_SHIFT ? w_rdata : r_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_head   = r_head;
        n_idx    = r_idx;
        n_emit   = 1'b0;
        n_data   = '0;
        n_status = ST_OK;
        n_last   = 1'b1;
        w_we     = 1'b0;
        w_waddr  = phys(r_head, AW'(r_held));
        w_raddr  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                n_idx   = '0;
                unique case (r_mode) inside
                    MODE_PUSH_FRONT: begin
                        n_emit = 1'b1;
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_head_dec;
                            n_head  = w_head_dec;
                            n_held  = r_held + CW'(1);
                        end
                    end
                    MODE_PUSH_BACK, MODE_INSERT_NEW: begin
                        if (r_mode == MODE_INSERT_NEW && r_held != '0) begin
                            n_state = S_SCAN;
                        end else begin
                            n_emit = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we   = 1'b1;
                                n_held = r_held + CW'(1);
                            end
                        end
                    end
                    MODE_REMOVE: begin
                        if (r_held == '0) begin
                            n_emit   = 1'b1;
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    MODE_POP_FRONT, MODE_FRONT, MODE_BACK: begin
                        if (r_held == '0) begin
                            n_emit   = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_READ;
                            if (r_mode == MODE_BACK) begin
                                w_raddr = phys(r_head, w_tail);
                            end
                        end
                    end
                    MODE_READ_INDEX: begin
                        if (PW'(r_pos) >= PW'(r_held)) begin
                            n_emit   = 1'b1;
                            n_status = ST_RANGE;
                        end else begin
                            n_state = S_READ;
                            w_raddr = phys(r_head, AW'(PW'(r_pos)));
                        end
                    end
                    MODE_CLEAR: begin
                        n_emit = 1'b1;
                        n_held = '0;
                    end
                    MODE_DUMP_FWD, MODE_DUMP_REV: begin
                        if (r_held == '0) begin
                            n_emit   = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_DUMP;
                            if (r_mode == MODE_DUMP_REV) begin
                                w_raddr = phys(r_head, w_tail);
                            end
                        end
                    end
                    default: begin
                        n_emit = 1'b1;
                    end
                endcase
            end

            S_READ: begin
                n_state = S_IDLE;
                n_emit  = 1'b1;
                n_data  = w_rdata;
                if (r_mode == MODE_POP_FRONT) begin
                    n_head = phys(r_head, AW'(1));
                    n_held = r_held - CW'(1);
                end
            end

            S_SCAN: begin
                w_raddr = phys(r_head, w_idx_inc);
                n_idx   = w_idx_inc;
                if (w_rdata == r_value) begin
                    if (r_mode == MODE_INSERT_NEW) begin
                        n_state  = S_IDLE;
                        n_emit   = 1'b1;
                        n_status = ST_PRESENT;
                    end else if (w_at_end) begin
                        n_state = S_IDLE;
                        n_emit  = 1'b1;
                        n_held  = r_held - CW'(1);
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (w_at_end) begin
                    n_state = S_IDLE;
                    n_emit  = 1'b1;
                    if (r_mode == MODE_REMOVE) begin
                        n_status = ST_NOT_FOUND;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_we   = 1'b1;
                        n_held = r_held + CW'(1);
                    end
                end
            end

            S_SHIFT: begin
                // The entry just read moves one place towards the front.
                w_we    = 1'b1;
                w_waddr = phys(r_head, r_idx - AW'(1));
                w_raddr = phys(r_head, w_idx_inc);
                n_idx   = w_idx_inc;
                if (w_at_end) begin
                    n_state = S_IDLE;
                    n_emit  = 1'b1;
                    n_held  = r_held - CW'(1);
                end
            end

            S_DUMP: begin
                n_emit  = 1'b1;
                n_data  = w_rdata;
                n_last  = w_at_end;
                n_idx   = w_idx_inc;
                if (r_mode == MODE_DUMP_FWD) begin
                    w_raddr = phys(r_head, w_idx_inc);
                end else begin
                    w_raddr = phys(r_head, AW'(r_held - CW'(2) - CW'(r_idx)));
                end
                if (w_at_end) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_out64  = 64'(n_data);
    assign w_held16 = 16'(n_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_head  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_head  <= n_head;
            o_valid <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        o_data   <= w_out64[DATA_W-1:0];
        o_status <= n_status;
        o_count  <= w_held16[COUNT_W-1:0];
        o_last   <= n_last;
        if (r_state == S_IDLE && start) begin
            r_mode  <= i_mode;
            r_value <= w_in64[DATA_WIDTH-1:0];
            r_pos   <= i_position;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
